@@ sv/kv_pool_mask_builder_assert.svh @@
// assertion macros for the pool mask builder
`ifndef KV_POOL_MASK_BUILDER_ASSERT_SVH
`define KV_POOL_MASK_BUILDER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define KVPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kvpm assertion failed");
// checked at every edge
`define KVPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kvpm assertion failed");
`else
`define KVPM_ASSERT(lbl, prop)
`define KVPM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/kvpm_pkg.sv @@
package kvpm_pkg;

  localparam int CELLS         = 1024;
  localparam int MAX_POOLS     = 64;
  localparam int MAX_POOL_SIZE = 64;
  localparam int SEQUENCES     = 16;
  localparam int SLOT_DEPTH    = MAX_POOLS * MAX_POOL_SIZE;
  localparam logic [6:0]  NO_POOL  = 7'd64;
  localparam logic [10:0] FILL_MAX = 11'd2047;

  // register addresses (word index)
  localparam logic [1:0] REG_POOL_SIZE   = 2'd0;
  localparam logic [1:0] REG_POOL_COUNT  = 2'd1;
  localparam logic [1:0] REG_TAIL_SELECT = 2'd2;

  // bias codes
  localparam logic [1:0] BIAS_MASKED = 2'd0;
  localparam logic [1:0] BIAS_POOLED = 2'd1;
  localparam logic [1:0] BIAS_TAIL   = 2'd2;

  typedef enum logic [2:0] {
    KIND_CLEAR     = 3'd0,
    KIND_LOAD      = 3'd1,
    KIND_READ_CELL = 3'd2,
    KIND_READ_SLOT = 3'd3,
    KIND_QUERY     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_CELL,
    ST_OLD,
    ST_DEC,
    ST_RD_B,
    ST_RD_SLOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       occ;
    logic [6:0] mark;
  } cell_entry_t;

  typedef struct packed {
    logic [30:0] pos;
    logic [15:0] seqs;
  } cell_data_t;

endpackage

@@ sv/kv_pool_mask_builder.sv @@
// Key-cache pool mask builder. One request in, one result out, for every kind.
// Load, slot read and query requests run a restoring divider (one quotient bit
// per cycle). Then come single-port memory reads and writes and a finish state
// that hands off the result: a slot read passes ST_RD_SLOT, a query ST_RD_CELL
// and ST_OLD, a load ST_RD_CELL, ST_OLD, ST_DEC and ST_RD_B. A cell read passes
// ST_RD_CELL and ST_OLD without the divider; an unknown kind goes to finish.
// After reset and for every clear request the block sweeps the slot memory,
// clearing the cell and fill memories as well, and accepts no request meanwhile;
// the clear request's result follows the sweep. A finished result waits in an output
// register while the next request is taken; a result that is still not taken
// holds the block in its finish state.
`include "kv_pool_mask_builder_assert.svh"

module kv_pool_mask_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cell_index, slot_index, cell_occupied, cell_position, cell_sequences,
  // query_sequence, query_position, zero fill
  input  logic [111:0] in_tdata,
  // kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pool_index, pool_usable, slot_cell, bias_code, zero fill
  output logic [23:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // config registers
  logic [6:0] pool_size_r, pool_count_r;
  logic       tail_select_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r   <= 7'd64;
      pool_count_r  <= 7'd64;
      tail_select_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        kvpm_pkg::REG_POOL_SIZE:   pool_size_r   <= cfg_pwdata[6:0];
        kvpm_pkg::REG_POOL_COUNT:  pool_count_r  <= cfg_pwdata[6:0];
        kvpm_pkg::REG_TAIL_SELECT: tail_select_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      kvpm_pkg::REG_POOL_SIZE:   cfg_prdata = {25'd0, pool_size_r};
      kvpm_pkg::REG_POOL_COUNT:  cfg_prdata = {25'd0, pool_count_r};
      kvpm_pkg::REG_TAIL_SELECT: cfg_prdata = {31'd0, tail_select_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // clamped sizes
  logic [6:0] es, ec;
  always_comb begin
    es = pool_size_r;
    if (pool_size_r == 7'd0) es = 7'd1;
    else if (pool_size_r > 7'(kvpm_pkg::MAX_POOL_SIZE)) es = 7'(kvpm_pkg::MAX_POOL_SIZE);
    ec = pool_count_r;
    if (pool_count_r == 7'd0) ec = 7'd1;
    else if (pool_count_r > 7'(kvpm_pkg::MAX_POOLS)) ec = 7'(kvpm_pkg::MAX_POOLS);
  end

  // request fields
  kvpm_pkg::kind_t kind_r;
  logic [9:0]  cell_r;
  logic [11:0] slot_r;
  logic        occ_r;
  logic [30:0] pos_r;
  logic [15:0] seqs_r;
  logic [3:0]  qseq_r;
  logic [30:0] qpos_r;

  kvpm_pkg::state_t state_r, state_nxt;
  logic        clr_item_r;
  logic [11:0] clr_idx_r;
  logic [31:0] div_num_r;
  logic [6:0]  rem_r;
  logic [4:0]  div_cnt_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;

  logic in_acc, out_free;
  assign in_tready = (state_r == kvpm_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // memories
  kvpm_pkg::cell_entry_t cell_mem [kvpm_pkg::CELLS];
  kvpm_pkg::cell_data_t  pos_mem  [kvpm_pkg::CELLS];
  logic [10:0]           fill_mem [kvpm_pkg::MAX_POOLS];
  logic [9:0]            slot_mem [kvpm_pkg::SLOT_DEPTH];

  kvpm_pkg::cell_entry_t cell_q, cell_wdata;
  kvpm_pkg::cell_data_t  pos_q;
  logic [10:0] fill_q, fill_wdata;
  logic [9:0]  slot_q, slot_wdata;
  logic        cell_re, fill_re, slot_re;
  logic        cell_we, pos_we, fill_we, slot_we;
  logic [9:0]  cell_waddr;
  logic [5:0]  fill_raddr, fill_waddr;
  logic [11:0] slot_waddr;

  // divider step
  logic [7:0] rem_t;
  logic       div_ge;
  assign rem_t  = {rem_r, div_num_r[31]};
  assign div_ge = rem_t >= {1'b0, es};

  // decoded state of the request
  logic        old_ok, load_hit, pool_ok, cell_ok;
  logic [12:0] slot_addr_w;
  logic [13:0] slot_lim;
  logic [31:0] qp1, tail;
  logic        q_hit;
  logic [23:0] result;
  logic [5:0]  r_pool;
  logic        r_usable;
  logic [9:0]  r_slot;
  logic [1:0]  r_bias;

  always_comb begin
    cell_ok     = {1'b0, cell_r} < 11'(kvpm_pkg::CELLS);
    old_ok      = cell_q.mark < kvpm_pkg::NO_POOL;
    load_hit    = occ_r && (div_num_r < {25'd0, ec});
    pool_ok     = (cell_q.mark < ec) && (fill_q >= {4'd0, es});
    slot_addr_w = 13'(div_num_r[5:0] * es) + {6'd0, rem_r};
    slot_lim    = 14'(ec * es);
    qp1         = {1'b0, qpos_r} + 32'd1;
    tail        = tail_select_r ? qp1 - {25'd0, rem_r} : qp1;
    q_hit       = cell_q.occ && ({28'd0, qseq_r} < 32'(kvpm_pkg::SEQUENCES)) &&
                  pos_q.seqs[qseq_r] && (pos_q.pos <= qpos_r);
    r_pool   = 6'd0;
    r_usable = 1'b0;
    r_slot   = 10'd0;
    r_bias   = kvpm_pkg::BIAS_MASKED;
    case (kind_r)
      kvpm_pkg::KIND_READ_CELL: begin
        if (cell_ok && old_ok && pool_ok) begin
          r_pool   = cell_q.mark[5:0];
          r_usable = 1'b1;
        end
      end
      kvpm_pkg::KIND_READ_SLOT: begin
        if ({2'd0, slot_r} < slot_lim && fill_q >= {4'd0, es}) r_slot = slot_q;
      end
      kvpm_pkg::KIND_QUERY: begin
        if (cell_ok && q_hit) begin
          if ({1'b0, pos_q.pos} >= tail) r_bias = kvpm_pkg::BIAS_TAIL;
          else if (old_ok && pool_ok)    r_bias = kvpm_pkg::BIAS_POOLED;
        end
      end
      default: ;
    endcase
    result = {5'd0, r_bias, r_slot, r_usable, r_pool};
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_nxt  = state_r;
    cell_re    = 1'b0;
    fill_re    = 1'b0;
    slot_re    = 1'b0;
    cell_we    = 1'b0;
    pos_we     = 1'b0;
    fill_we    = 1'b0;
    slot_we    = 1'b0;
    cell_waddr = cell_r;
    cell_wdata = '{occ: occ_r, mark: load_hit ? div_num_r[6:0] : kvpm_pkg::NO_POOL};
    fill_raddr = div_num_r[5:0];
    fill_waddr = div_num_r[5:0];
    fill_wdata = (fill_q < kvpm_pkg::FILL_MAX) ? fill_q + 11'd1 : fill_q;
    slot_waddr = slot_addr_w[11:0];
    slot_wdata = cell_r;
    case (state_r)
      kvpm_pkg::ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx_r;
        slot_wdata = 10'd0;
        cell_we    = {1'b0, clr_idx_r} < 13'(kvpm_pkg::CELLS);
        cell_waddr = clr_idx_r[9:0];
        cell_wdata = '{occ: 1'b0, mark: kvpm_pkg::NO_POOL};
        fill_we    = {1'b0, clr_idx_r} < 13'(kvpm_pkg::MAX_POOLS);
        fill_waddr = clr_idx_r[5:0];
        fill_wdata = 11'd0;
        if (clr_idx_r == 12'(kvpm_pkg::SLOT_DEPTH - 1))
          state_nxt = clr_item_r ? kvpm_pkg::ST_FINISH : kvpm_pkg::ST_IDLE;
      end
      kvpm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kvpm_pkg::kind_t'(in_tuser))
            kvpm_pkg::KIND_CLEAR:     state_nxt = kvpm_pkg::ST_CLEAR;
            kvpm_pkg::KIND_LOAD,
            kvpm_pkg::KIND_READ_SLOT,
            kvpm_pkg::KIND_QUERY:     state_nxt = kvpm_pkg::ST_DIV;
            kvpm_pkg::KIND_READ_CELL: state_nxt = kvpm_pkg::ST_RD_CELL;
            default:                  state_nxt = kvpm_pkg::ST_FINISH;
          endcase
        end
      end
      kvpm_pkg::ST_DIV: begin
        if (div_cnt_r == 5'd0)
          state_nxt = (kind_r == kvpm_pkg::KIND_READ_SLOT) ? kvpm_pkg::ST_RD_SLOT
                                                            : kvpm_pkg::ST_RD_CELL;
      end
      kvpm_pkg::ST_RD_CELL: begin
        cell_re   = 1'b1;
        state_nxt = kvpm_pkg::ST_OLD;
      end
      kvpm_pkg::ST_OLD: begin
        fill_re    = 1'b1;
        fill_raddr = cell_q.mark[5:0];
        state_nxt  = (kind_r == kvpm_pkg::KIND_LOAD && cell_ok) ? kvpm_pkg::ST_DEC
                                                                 : kvpm_pkg::ST_FINISH;
      end
      kvpm_pkg::ST_DEC: begin
        // withdraw the old count and rewrite the cell
        fill_we    = old_ok && (fill_q != 11'd0);
        fill_waddr = cell_q.mark[5:0];
        fill_wdata = fill_q - 11'd1;
        cell_we    = 1'b1;
        pos_we     = 1'b1;
        state_nxt  = kvpm_pkg::ST_RD_B;
      end
      kvpm_pkg::ST_RD_B: begin
        fill_re   = 1'b1;
        state_nxt = kvpm_pkg::ST_FINISH;
      end
      kvpm_pkg::ST_RD_SLOT: begin
        fill_re   = 1'b1;
        slot_re   = 1'b1;
        state_nxt = kvpm_pkg::ST_FINISH;
      end
      kvpm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = kvpm_pkg::ST_IDLE;
          if (kind_r == kvpm_pkg::KIND_LOAD && cell_ok && load_hit) begin
            fill_we = 1'b1;
            slot_we = 1'b1;
          end
        end
      end
      default: state_nxt = kvpm_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kvpm_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // control counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_item_r  <= 1'b0;
      clr_idx_r   <= 12'd0;
      div_cnt_r   <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == kvpm_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + 12'd1;
      if (state_r == kvpm_pkg::ST_DIV)   div_cnt_r <= div_cnt_r - 5'd1;
      if (in_acc) begin
        clr_item_r <= kvpm_pkg::kind_t'(in_tuser) == kvpm_pkg::KIND_CLEAR;
        clr_idx_r  <= 12'd0;
        div_cnt_r  <= 5'd31;
      end
      // a new result replaces one taken in the same cycle
      if (state_r == kvpm_pkg::ST_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                            out_valid_r <= 1'b0;
    end
  end

  // request fields, divider and result data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= kvpm_pkg::kind_t'(in_tuser);
      cell_r <= in_tdata[9:0];
      slot_r <= in_tdata[21:10];
      occ_r  <= in_tdata[22];
      pos_r  <= in_tdata[53:23];
      seqs_r <= in_tdata[69:54];
      qseq_r <= in_tdata[73:70];
      qpos_r <= in_tdata[104:74];
      rem_r  <= 7'd0;
      case (kvpm_pkg::kind_t'(in_tuser))
        kvpm_pkg::KIND_LOAD:      div_num_r <= {1'b0, in_tdata[53:23]};
        kvpm_pkg::KIND_READ_SLOT: div_num_r <= {20'd0, in_tdata[21:10]};
        default:                  div_num_r <= {1'b0, in_tdata[104:74]} + 32'd1;
      endcase
    end else if (state_r == kvpm_pkg::ST_DIV) begin
      rem_r     <= div_ge ? 7'(rem_t - {1'b0, es}) : rem_t[6:0];
      div_num_r <= {div_num_r[30:0], div_ge};
    end
    if (state_r == kvpm_pkg::ST_FINISH && out_free) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) cell_q <= cell_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[cell_r] <= '{pos: pos_r, seqs: seqs_r};
    if (cell_re) pos_q <= pos_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_q <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_q <= slot_mem[slot_r];
  end

  // checks
  `KVPM_ASSERT(a_accept_starts, in_acc |=> state_r != kvpm_pkg::ST_IDLE)
  `KVPM_ASSERT(a_clear_no_result, (state_r == kvpm_pkg::ST_CLEAR) |=> !$rose(out_tvalid))
  `KVPM_ASSERT_ALWAYS(a_fill_bound, fill_we |-> fill_wdata <= kvpm_pkg::FILL_MAX)

endmodule
